// ===== design/pab_pkg.sv =====
// Package for the palette alpha blender: channel types, item codes and the divide-by-255 helper.
package pab_pkg;

   // Width of one color channel and of a color index
   localparam int unsigned CHAN_W = 8;
   localparam int unsigned INDEX_W = 8;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [INDEX_W-1:0] index_type;

   // Packed palette entry as stored in the palette memory
   typedef struct packed {
      chan_type alpha;
      chan_type blue;
      chan_type green;
      chan_type red;
   } entry_type;

   // Weighted sum of two channels, at most 255*255
   typedef logic [2*CHAN_W-1:0] wsum_type;

   // Transaction kinds on the request channel
   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   // floor(sum / 255) for sum <= 255*255: (sum + 1 + sum/256) / 256
   function automatic chan_type div255(input wsum_type sum);
      logic [2*CHAN_W:0] tmp;
      tmp = {1'b0, sum} + (2*CHAN_W+1)'(1) + (2*CHAN_W+1)'(sum[2*CHAN_W-1:CHAN_W]);
      return tmp[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

// ===== design/pab_req_if.sv =====
// Request channel interface: pixel and palette-write transactions.
interface pab_req_if;
   import pab_pkg::*;

   logic      valid;
   logic      ready;
   kind_type  kind;
   index_type color_index;
   chan_type  dest_red;
   chan_type  dest_green;
   chan_type  dest_blue;
   logic      bank_select;
   chan_type  entry_red;
   chan_type  entry_green;
   chan_type  entry_blue;
   chan_type  entry_alpha;

   modport source (
      output valid, kind, color_index, dest_red, dest_green, dest_blue,
             bank_select, entry_red, entry_green, entry_blue, entry_alpha,
      input  ready
   );

   modport sink (
      input  valid, kind, color_index, dest_red, dest_green, dest_blue,
             bank_select, entry_red, entry_green, entry_blue, entry_alpha,
      output ready
   );
endinterface

// ===== design/pab_rsp_if.sv =====
// Response channel interface: blended pixel transactions.
interface pab_rsp_if;
   import pab_pkg::*;

   logic     valid;
   logic     ready;
   chan_type out_red;
   chan_type out_green;
   chan_type out_blue;
   logic     pixel_changed;

   modport source (
      output valid, out_red, out_green, out_blue, pixel_changed,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue, pixel_changed,
      output ready
   );
endinterface

// ===== design/palette_alpha_blender.sv =====
// Palette alpha blender top level: palette memory and three-stage blend pipeline.
//
//   channel  | dir | transaction
//   ---------+-----+--------------------------------------------------
//   req_if   | in  | pixel to blend, or palette entry to write
//   rsp_if   | out | blended pixel, one per pixel transaction
//   csr_*    | in  | use_alt_palette bank select, write only
//
// One transaction per clock while the output is not stalled. A pixel's result
// passes through the memory read, multiply-add and divide-by-255 registers; palette writes
// land in memory at acceptance and give no result.
// Reset clears the pipeline valid bits and the bank select; the palette
// memory is not cleared. Each stage holds while the one after it is full
// and stalled, so empty stages still fill during an output stall.
module palette_alpha_blender #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   pab_req_if.sink          req_if,
   pab_rsp_if.source        rsp_if,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);
   import pab_pkg::*;

   localparam int unsigned DEPTH = 2 * PALETTE_ENTRIES;
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CMP_W = INDEX_W + 1;

   // Configuration register
   logic use_alt_palette_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_alt_palette_ff <= 1'b0;
      end else if (csr_write_enable) begin
         use_alt_palette_ff <= csr_write_data;
      end
   end

   // Stage enables: a stage advances when it is empty or the next one advances
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   assign en3 = !v3_ff || rsp_if.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_if.ready = en1;

   // Request decode
   logic            req_accept;
   logic            in_range;
   logic            is_pixel;
   logic            blend_in;
   logic [AW-1:0]   idx_addr;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;

   assign req_accept = req_if.valid && en1;
   assign is_pixel   = (req_if.kind == KIND_PIXEL);
   assign in_range   = ({1'b0, req_if.color_index} < CMP_W'(PALETTE_ENTRIES));
   assign blend_in   = in_range && (req_if.color_index != '0);
   assign idx_addr   = AW'(req_if.color_index);
   assign wr_addr    = req_if.bank_select ? idx_addr + AW'(PALETTE_ENTRIES) : idx_addr;
   assign rd_addr    = use_alt_palette_ff ? idx_addr + AW'(PALETTE_ENTRIES) : idx_addr;

   // Palette memory: write at acceptance, registered read into stage 1
   entry_type mem [DEPTH];
   entry_type entry1_ff;

   always_ff @(posedge clock) begin
      if (req_accept && !is_pixel && in_range) begin
         mem[wr_addr] <= '{alpha: req_if.entry_alpha, blue: req_if.entry_blue,
                           green: req_if.entry_green, red: req_if.entry_red};
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_pixel && blend_in) begin
         entry1_ff <= mem[rd_addr];
      end
   end

   // Stage 1: destination pixel and blend flag
   logic     blend1_ff;
   chan_type dr1_ff, dg1_ff, db1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_accept && is_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         blend1_ff <= blend_in;
         dr1_ff    <= req_if.dest_red;
         dg1_ff    <= req_if.dest_green;
         db1_ff    <= req_if.dest_blue;
      end
   end

   // Stage 2: a*pal + (255-a)*dst per channel
   chan_type inv_alpha;
   wsum_type sr_in, sg_in, sb_in;
   wsum_type sr2_ff, sg2_ff, sb2_ff;
   logic     blend2_ff;
   chan_type dr2_ff, dg2_ff, db2_ff;

   assign inv_alpha = ~entry1_ff.alpha;
   assign sr_in = wsum_type'(entry1_ff.alpha * entry1_ff.red) + wsum_type'(inv_alpha * dr1_ff);
   assign sg_in = wsum_type'(entry1_ff.alpha * entry1_ff.green)
                + wsum_type'(inv_alpha * dg1_ff);
   assign sb_in = wsum_type'(entry1_ff.alpha * entry1_ff.blue) + wsum_type'(inv_alpha * db1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         sr2_ff    <= sr_in;
         sg2_ff    <= sg_in;
         sb2_ff    <= sb_in;
         blend2_ff <= blend1_ff;
         dr2_ff    <= dr1_ff;
         dg2_ff    <= dg1_ff;
         db2_ff    <= db1_ff;
      end
   end

   // Stage 3: divide by 255 or pass through, output register
   chan_type or_ff, og_ff, ob_ff;
   logic     changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         or_ff      <= blend2_ff ? div255(sr2_ff) : dr2_ff;
         og_ff      <= blend2_ff ? div255(sg2_ff) : dg2_ff;
         ob_ff      <= blend2_ff ? div255(sb2_ff) : db2_ff;
         changed_ff <= blend2_ff;
      end
   end

   assign rsp_if.valid         = v3_ff;
   assign rsp_if.out_red       = or_ff;
   assign rsp_if.out_green     = og_ff;
   assign rsp_if.out_blue      = ob_ff;
   assign rsp_if.pixel_changed = changed_ff;

endmodule

// ===== design/pab_checker.sv =====
// Port-level checker for the palette alpha blender, bound to the top level.
module pab_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_changed
);

   // A pending response stays until taken
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_red, rsp_green, rsp_blue, rsp_changed}))
      else $error("response payload changed while stalled");

   // An empty output register never blocks the request side
   ready_when_empty: assert property (@(posedge clock)
      !rsp_valid |-> req_ready)
      else $error("request stalled with output empty");

   // Reset empties the pipeline
   empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind palette_alpha_blender pab_checker u_pab_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_red     (rsp_if.out_red),
   .rsp_green   (rsp_if.out_green),
   .rsp_blue    (rsp_if.out_blue),
   .rsp_changed (rsp_if.pixel_changed)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the palette alpha blender: random palette and pixel traffic.
module tb;
   import pab_pkg::*;

   localparam int unsigned NUM_ENTRIES  = 256;
   localparam int unsigned PIPE_CYCLES  = 3;
   localparam int unsigned QUIET_LIMIT  = 4000;
   localparam int unsigned PHASE_ITEMS  = 190;
   localparam int unsigned PHASE_COUNT  = 6;

   // One request transaction as the driver sends it
   typedef struct {
      kind_type  kind;
      index_type color_index;
      chan_type  dest_red;
      chan_type  dest_green;
      chan_type  dest_blue;
      logic      bank_select;
      entry_type entry;
   } request_type;

   // One blended pixel as the block should return it
   typedef struct {
      chan_type red;
      chan_type green;
      chan_type blue;
      logic     changed;
   } pixel_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   pab_req_if req_chan ();
   pab_rsp_if rsp_chan ();

   palette_alpha_blender #(
      .PALETTE_ENTRIES (NUM_ENTRIES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_chan),
      .rsp_if           (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: shadow palette banks and the bank-select copy
   entry_type palette_shadow [2][NUM_ENTRIES];
   logic      bank_mode;

   // Generator bookkeeping: which entries have been written so far
   bit        entry_written [2][NUM_ENTRIES];
   index_type last_written_index;

   request_type pending_requests [$];
   pixel_type   expected_pixels [$];
   request_type cur_req;

   int unsigned mismatch_count;
   int          req_gap_left;
   int          rsp_stall_left;
   bit          req_idle_on;
   bit          rsp_idle_on;

   // Clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Idle length: mostly none or short, a few long
   function automatic int pick_gap(bit enabled);
      int unsigned roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Channel value biased toward the extremes
   function automatic chan_type rand_chan();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'd0;
      if (roll == 1) return 8'd255;
      return chan_type'($urandom_range(0, 255));
   endfunction

   function automatic chan_type rand_alpha();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0, 1: return 8'd0;
         2, 3: return 8'd255;
         4: return 8'd1;
         5: return 8'd254;
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   // floor((a*p + (255-a)*d) / 255)
   function automatic chan_type mix_chan(chan_type alpha, chan_type pal, chan_type dst);
      int unsigned sum;
      sum = alpha * pal + (255 - alpha) * dst;
      return chan_type'(sum / 255);
   endfunction

   // Predict the effect of one accepted request transaction
   function automatic void apply_request(request_type rq);
      pixel_type px;
      entry_type ent;
      if (rq.kind == KIND_WRITE) begin
         if (rq.color_index < NUM_ENTRIES)
            palette_shadow[rq.bank_select][rq.color_index] = rq.entry;
      end else begin
         if (rq.color_index == 0 || rq.color_index >= NUM_ENTRIES) begin
            px.red     = rq.dest_red;
            px.green   = rq.dest_green;
            px.blue    = rq.dest_blue;
            px.changed = 1'b0;
         end else begin
            ent        = palette_shadow[bank_mode][rq.color_index];
            px.red     = mix_chan(ent.alpha, ent.red, rq.dest_red);
            px.green   = mix_chan(ent.alpha, ent.green, rq.dest_green);
            px.blue    = mix_chan(ent.alpha, ent.blue, rq.dest_blue);
            px.changed = 1'b1;
         end
         expected_pixels.push_back(px);
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Compare one response transaction against the oldest expected pixel
   task automatic check_pixel();
      pixel_type px;
      if (expected_pixels.size() == 0) begin
         report_mismatch("response with no pixel expected");
      end else begin
         px = expected_pixels.pop_front();
         if (rsp_chan.out_red !== px.red)
            report_mismatch($sformatf("out_red %0h, want %0h", rsp_chan.out_red, px.red));
         if (rsp_chan.out_green !== px.green)
            report_mismatch($sformatf("out_green %0h, want %0h",
                                      rsp_chan.out_green, px.green));
         if (rsp_chan.out_blue !== px.blue)
            report_mismatch($sformatf("out_blue %0h, want %0h", rsp_chan.out_blue, px.blue));
         if (rsp_chan.pixel_changed !== px.changed)
            report_mismatch($sformatf("pixel_changed %0b, want %0b",
                                      rsp_chan.pixel_changed, px.changed));
      end
   endtask

   // Queue a palette write; dest fields carry random filler
   task automatic queue_write(logic bank, index_type idx, chan_type r, chan_type g,
                              chan_type b, chan_type a);
      request_type rq;
      rq.kind        = KIND_WRITE;
      rq.color_index = idx;
      rq.dest_red    = chan_type'($urandom_range(0, 255));
      rq.dest_green  = chan_type'($urandom_range(0, 255));
      rq.dest_blue   = chan_type'($urandom_range(0, 255));
      rq.bank_select = bank;
      rq.entry.red   = r;
      rq.entry.green = g;
      rq.entry.blue  = b;
      rq.entry.alpha = a;
      pending_requests.push_back(rq);
      if (idx < NUM_ENTRIES) begin
         entry_written[bank][idx] = 1'b1;
         last_written_index = idx;
      end
   endtask

   // Queue a pixel; an unwritten entry in the active bank gets written first
   task automatic queue_pixel(index_type idx, chan_type dr, chan_type dg, chan_type db);
      request_type rq;
      if (idx != 0 && idx < NUM_ENTRIES && !entry_written[bank_mode][idx])
         queue_write(bank_mode, idx, rand_chan(), rand_chan(), rand_chan(), rand_alpha());
      rq.kind        = KIND_PIXEL;
      rq.color_index = idx;
      rq.dest_red    = dr;
      rq.dest_green  = dg;
      rq.dest_blue   = db;
      rq.bank_select = logic'($urandom_range(0, 1));
      rq.entry       = entry_type'($urandom());
      pending_requests.push_back(rq);
   endtask

   // Sender holds off until the pipeline has drained completely
   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_chan.valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (PIPE_CYCLES + 2) @(posedge clock);
   endtask

   // Write the bank-select register while the block is idle
   task automatic set_bank_mode(logic alt);
      wait_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= alt;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      bank_mode = alt;
      repeat (2) @(posedge clock);
   endtask

   // Random mix of palette writes and pixels, with read-after-write bias
   task automatic queue_random(int unsigned count);
      int unsigned roll;
      index_type   idx;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0: idx = 8'd0;
            1: idx = 8'd255;
            2: idx = last_written_index;
            default: idx = index_type'($urandom_range(1, 255));
         endcase
         if (roll < 30)
            queue_write(logic'($urandom_range(0, 1)), idx, rand_chan(), rand_chan(),
                        rand_chan(), rand_alpha());
         else
            queue_pixel(idx, rand_chan(), rand_chan(), rand_chan());
      end
   endtask

   // Driver: presents queued request transactions, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_request(cur_req);
            if ($urandom_range(0, 199) == 0) req_idle_on = !req_idle_on;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               cur_req = pending_requests.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.kind        <= cur_req.kind;
               req_chan.color_index <= cur_req.color_index;
               req_chan.dest_red    <= cur_req.dest_red;
               req_chan.dest_green  <= cur_req.dest_green;
               req_chan.dest_blue   <= cur_req.dest_blue;
               req_chan.bank_select <= cur_req.bank_select;
               req_chan.entry_red   <= cur_req.entry.red;
               req_chan.entry_green <= cur_req.entry.green;
               req_chan.entry_blue  <= cur_req.entry.blue;
               req_chan.entry_alpha <= cur_req.entry.alpha;
               req_gap_left = pick_gap(req_idle_on);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks response transactions and applies random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_pixel();
            if ($urandom_range(0, 149) == 0) rsp_idle_on = !rsp_idle_on;
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_stall_left = pick_gap(rsp_idle_on);
         end
      end
   end

   // Watchdog: too long without any transaction ends the run
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus sequence
   initial begin
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.kind        = KIND_PIXEL;
      req_chan.color_index = '0;
      req_chan.dest_red    = '0;
      req_chan.dest_green  = '0;
      req_chan.dest_blue   = '0;
      req_chan.bank_select = 1'b0;
      req_chan.entry_red   = '0;
      req_chan.entry_green = '0;
      req_chan.entry_blue  = '0;
      req_chan.entry_alpha = '0;
      rsp_chan.ready       = 1'b0;
      mismatch_count       = 0;
      bank_mode            = 1'b0;
      last_written_index   = 8'd1;
      req_idle_on          = 1'b1;
      rsp_idle_on          = 1'b1;
      for (int b = 0; b < 2; b++)
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            palette_shadow[b][i] = '0;
            entry_written[b][i]  = 1'b0;
         end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed, normal bank: opaque, clear, half and entry zero
      set_bank_mode(1'b0);
      queue_write(1'b0, 8'd1, 8'd12, 8'd34, 8'd56, 8'd255);
      queue_write(1'b0, 8'd2, 8'd255, 8'd255, 8'd255, 8'd0);
      queue_write(1'b0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd128);
      queue_write(1'b0, 8'd0, 8'd77, 8'd88, 8'd99, 8'd200);
      queue_write(1'b1, 8'd1, 8'd200, 8'd100, 8'd50, 8'd255);
      queue_write(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1);
      queue_pixel(8'd0, 8'd255, 8'd255, 8'd255);
      queue_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      queue_pixel(8'd1, 8'd0, 8'd0, 8'd0);
      queue_pixel(8'd1, 8'd255, 8'd255, 8'd255);
      queue_pixel(8'd2, 8'd255, 8'd0, 8'd128);
      queue_pixel(8'd255, 8'd0, 8'd0, 8'd0);
      queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);
      // Overwrite then read of the same entry, queued one after the other
      queue_write(1'b0, 8'd1, 8'd0, 8'd255, 8'd0, 8'd254);
      queue_pixel(8'd1, 8'd255, 8'd0, 8'd255);

      // Directed, alternate bank
      set_bank_mode(1'b1);
      queue_pixel(8'd1, 8'd0, 8'd128, 8'd255);
      queue_pixel(8'd255, 8'd0, 8'd0, 8'd0);
      queue_pixel(8'd0, 8'd1, 8'd2, 8'd3);
      queue_write(1'b0, 8'd2, 8'd9, 8'd9, 8'd9, 8'd255);
      queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);

      // Random phases, alternating the bank select between them
      for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
         set_bank_mode(logic'(p % 2 == 0 ? 0 : 1));
         queue_random(PHASE_ITEMS);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
